### rtl/lfc_pkg.sv
// ----------------------------------------------------------------------------
// lfc_pkg: shared definitions of the line follow controller
// Field widths, fixed hold times, mode and register codes, the configuration
// record and the command and status records between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lfc_pkg;

  localparam int unsigned SENSOR_BITS   = 12;
  localparam int unsigned VEL_BITS      = 13;
  localparam int unsigned HOLD_BITS     = 14;
  localparam int unsigned MODE_BITS     = 2;
  localparam int unsigned THR_BITS      = 14;
  localparam int unsigned SPEED_BITS    = 11;
  localparam int unsigned GAIN_BITS     = 12;
  localparam int unsigned LIMIT_BITS    = 4;
  localparam int unsigned TURN_MS_BITS  = 13;
  localparam int unsigned ERR_BITS      = 15;
  localparam int unsigned ERR_FRAC      = 14;
  localparam int unsigned REG_IDX_BITS  = 3;
  localparam int unsigned APB_ADDR_BITS = REG_IDX_BITS + 2;
  localparam int unsigned APB_DATA_BITS = 32;

  localparam logic [HOLD_BITS-1:0] HOLD_PERIOD = 14'd100;
  localparam logic [HOLD_BITS-1:0] HOLD_START  = 14'd5100;
  localparam logic [HOLD_BITS-1:0] HOLD_BODY   = 14'd533;

  localparam logic [MODE_BITS-1:0] MODE_START  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_SEEK   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_FOLLOW = 2'd2;

  localparam logic [REG_IDX_BITS-1:0] REG_CRUISE  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_GAIN    = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_LOST    = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_BRIGHT  = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_JOIN    = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_LIMIT   = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_QUARTER = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_HALF    = 3'd7;

  localparam logic [SPEED_BITS-1:0]   RST_CRUISE  = 11'd384;
  localparam logic [GAIN_BITS-1:0]    RST_GAIN    = 12'd2048;
  localparam logic [THR_BITS-1:0]     RST_LOST    = 14'd1000;
  localparam logic [THR_BITS-1:0]     RST_BRIGHT  = 14'd2500;
  localparam logic [THR_BITS-1:0]     RST_JOIN    = 14'd2400;
  localparam logic [LIMIT_BITS-1:0]   RST_LIMIT   = 4'd10;
  localparam logic [TURN_MS_BITS-1:0] RST_QUARTER = 13'd1267;
  localparam logic [TURN_MS_BITS-1:0] RST_HALF    = 13'd2533;

  typedef struct packed {
    logic [SPEED_BITS-1:0]   cruise_speed;
    logic [GAIN_BITS-1:0]    turn_gain;
    logic [THR_BITS-1:0]     lost_threshold;
    logic [THR_BITS-1:0]     bright_threshold;
    logic [THR_BITS-1:0]     join_threshold;
    logic [LIMIT_BITS-1:0]   straight_limit;
    logic [TURN_MS_BITS-1:0] quarter_turn_ms;
    logic [TURN_MS_BITS-1:0] half_turn_ms;
  } cfg_t;

  typedef enum logic [2:0] {
    CMD_STOP,
    CMD_FWD,
    CMD_HELD,
    CMD_BODY,
    CMD_SPIN_Q,
    CMD_SPIN_H,
    CMD_STEER
  } cmd_kind_e;

  typedef struct packed {
    logic                 load_sens;
    logic                 div_start;
    logic                 mul_load;
    logic                 out_load;
    cmd_kind_e            kind;
    logic                 last;
    logic [MODE_BITS-1:0] mode_now;
  } dp_cmd_t;

  typedef struct packed {
    logic sum_gt_join;
    logic sum_lt_lost;
    logic sum_gt_bright;
    logic div_busy;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/lfc_if.sv
// ----------------------------------------------------------------------------
// lfc_if: sensor and wheel command channels
// Valid/ready channels that carry one control period's sensor readings and
// one timed wheel command.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfc_sens_if import lfc_pkg::*; #(
  parameter int unsigned SensorBits = SENSOR_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [SensorBits-1:0] left_sensor;
  logic [SensorBits-1:0] center_sensor;
  logic [SensorBits-1:0] right_sensor;

  modport source (output valid, output left_sensor, output center_sensor,
                  output right_sensor, input ready);
  modport sink   (input valid, input left_sensor, input center_sensor,
                  input right_sensor, output ready);
endinterface

interface lfc_cmd_if import lfc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VEL_BITS-1:0] left_velocity;
  logic signed [VEL_BITS-1:0] right_velocity;
  logic [HOLD_BITS-1:0]       hold_ms;
  logic [MODE_BITS-1:0]       mode_now;
  logic                       last;

  modport source (output valid, output left_velocity, output right_velocity,
                  output hold_ms, output mode_now, output last, input ready);
  modport sink   (input valid, input left_velocity, input right_velocity,
                  input hold_ms, input mode_now, input last, output ready);
endinterface

`default_nettype wire

### rtl/line_follow_controller.sv
// ----------------------------------------------------------------------------
// line_follow_controller: three-sensor line follower
// Turns each control period's ground-sensor readings into one or two timed
// wheel velocity commands under start, seek and follow modes.
// ----------------------------------------------------------------------------
// Each accepted sensor transfer is worked on alone. For start, seek,
// bright-floor and lost-line periods the sequencer passes from the decide
// state to the emit state, which loads the command into the output register.
// The lost-line case loads its second command after the first. A
// proportional steering period starts the 15-step serial divider that forms
// the line error, waits in the divide state until it finishes, and loads the
// steering product in the multiply state before the emit state. The next
// sensor transfer is accepted once the last command is loaded, while it still
// waits to be taken; a stalled output delays further commands.
`default_nettype none

module line_follow_controller import lfc_pkg::*; #(
  parameter int unsigned SensorBits = SENSOR_BITS
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  lfc_sens_if.sink                      sens_i,
  lfc_cmd_if.source                     res_o,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready
);

  cfg_t       cfg;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic       in_ready;

  assign sens_i.ready = in_ready;

  lfc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lfc_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (sens_i.valid),
    .in_ready_o       (in_ready),
    .straight_limit_i (cfg.straight_limit),
    .status_i         (dp_status),
    .cmd_o            (dp_cmd)
  );

  lfc_dp #(
    .SensorBits (SensorBits)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (dp_cmd),
    .left_sensor_i   (sens_i.left_sensor),
    .center_sensor_i (sens_i.center_sensor),
    .right_sensor_i  (sens_i.right_sensor),
    .status_o        (dp_status),
    .res_o           (res_o)
  );

endmodule

`default_nettype wire

### rtl/lfc_regs.sv
// ----------------------------------------------------------------------------
// lfc_regs: configuration register file
// APB-style register bank holding the speed, gain, threshold and turn settings.
// ----------------------------------------------------------------------------
`default_nettype none

module lfc_regs import lfc_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready,
  output cfg_t                          cfg_o
);

  cfg_t                    cfg_q;
  logic                    wr_en;
  logic [REG_IDX_BITS-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[APB_ADDR_BITS-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cruise_speed     <= RST_CRUISE;
      cfg_q.turn_gain        <= RST_GAIN;
      cfg_q.lost_threshold   <= RST_LOST;
      cfg_q.bright_threshold <= RST_BRIGHT;
      cfg_q.join_threshold   <= RST_JOIN;
      cfg_q.straight_limit   <= RST_LIMIT;
      cfg_q.quarter_turn_ms  <= RST_QUARTER;
      cfg_q.half_turn_ms     <= RST_HALF;
    end else if (wr_en) begin
      unique case (idx)
        REG_CRUISE:  cfg_q.cruise_speed     <= pwdata[SPEED_BITS-1:0];
        REG_GAIN:    cfg_q.turn_gain        <= pwdata[GAIN_BITS-1:0];
        REG_LOST:    cfg_q.lost_threshold   <= pwdata[THR_BITS-1:0];
        REG_BRIGHT:  cfg_q.bright_threshold <= pwdata[THR_BITS-1:0];
        REG_JOIN:    cfg_q.join_threshold   <= pwdata[THR_BITS-1:0];
        REG_LIMIT:   cfg_q.straight_limit   <= pwdata[LIMIT_BITS-1:0];
        REG_QUARTER: cfg_q.quarter_turn_ms  <= pwdata[TURN_MS_BITS-1:0];
        REG_HALF:    cfg_q.half_turn_ms     <= pwdata[TURN_MS_BITS-1:0];
        default:     cfg_q.half_turn_ms     <= cfg_q.half_turn_ms;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CRUISE:  prdata = APB_DATA_BITS'(cfg_q.cruise_speed);
      REG_GAIN:    prdata = APB_DATA_BITS'(cfg_q.turn_gain);
      REG_LOST:    prdata = APB_DATA_BITS'(cfg_q.lost_threshold);
      REG_BRIGHT:  prdata = APB_DATA_BITS'(cfg_q.bright_threshold);
      REG_JOIN:    prdata = APB_DATA_BITS'(cfg_q.join_threshold);
      REG_LIMIT:   prdata = APB_DATA_BITS'(cfg_q.straight_limit);
      REG_QUARTER: prdata = APB_DATA_BITS'(cfg_q.quarter_turn_ms);
      REG_HALF:    prdata = APB_DATA_BITS'(cfg_q.half_turn_ms);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/lfc_div.sv
// ----------------------------------------------------------------------------
// lfc_div: serial line error divider
// Restoring divider that yields one quotient bit per cycle of the Q1.14 line
// error, for a dividend no larger than the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module lfc_div import lfc_pkg::*; #(
  parameter int unsigned DivW = SENSOR_BITS + 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [DivW-1:0]     dividend_i,
  input  wire logic [DivW-1:0]     divisor_i,
  output logic                     busy_o,
  output logic [ERR_BITS-1:0]      quot_o
);

  localparam int unsigned StepW = $clog2(ERR_BITS);
  localparam logic [StepW-1:0] LastStep = StepW'(ERR_BITS - 1);

  logic             busy_q;
  logic [StepW-1:0] step_q;
  logic [DivW-1:0]  rem_q;
  logic [ERR_BITS-1:0] quot_q;
  logic [DivW:0]    trial;
  logic [DivW:0]    trial_sub;
  logic             ge;

  // The first step compares the dividend itself; later steps shift in zeros.
  assign trial     = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign ge        = trial >= {1'b0, divisor_i};
  assign trial_sub = trial - {1'b0, divisor_i};
  assign busy_o    = busy_q;
  assign quot_o    = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == LastStep) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? trial_sub[DivW-1:0] : trial[DivW-1:0];
      quot_q <= {quot_q[ERR_BITS-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### rtl/lfc_dp.sv
// ----------------------------------------------------------------------------
// lfc_dp: line follow datapath
// Sensor registers, sum and threshold compares, line error divider, steering
// multiplier, velocity selection and saturation, held velocities and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfc_dp import lfc_pkg::*; #(
  parameter int unsigned SensorBits = SENSOR_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cfg_t                  cfg_i,
  input  wire dp_cmd_t               cmd_i,
  input  wire logic [SensorBits-1:0] left_sensor_i,
  input  wire logic [SensorBits-1:0] center_sensor_i,
  input  wire logic [SensorBits-1:0] right_sensor_i,
  output dp_status_t                 status_o,
  lfc_cmd_if.source                  res_o
);

  localparam int unsigned SumW  = SensorBits + 2;
  localparam int unsigned CmpW  = (SumW > THR_BITS) ? SumW : THR_BITS;
  localparam int unsigned ProdW = GAIN_BITS + ERR_BITS;
  localparam int unsigned TmagW = ProdW + 1 - ERR_FRAC;
  localparam int unsigned WideW = VEL_BITS + 3;
  localparam logic [ProdW:0] RoundHalf = (ProdW + 1)'(1 << (ERR_FRAC - 1));
  localparam logic signed [WideW-1:0] VelMax = WideW'((1 << (VEL_BITS - 1)) - 1);
  localparam logic signed [WideW-1:0] VelMin = ~VelMax;

  function automatic logic signed [VEL_BITS-1:0] sat_vel(
    input logic signed [WideW-1:0] v
  );
    logic signed [VEL_BITS-1:0] r;
    if (v > VelMax) begin
      r = VelMax[VEL_BITS-1:0];
    end else if (v < VelMin) begin
      r = VelMin[VEL_BITS-1:0];
    end else begin
      r = v[VEL_BITS-1:0];
    end
    return r;
  endfunction

  logic [SensorBits-1:0]      l_q, c_q, r_q;
  logic [SumW-1:0]            sum;
  logic [CmpW-1:0]            sum_c;
  logic                       neg;
  logic [SensorBits-1:0]      diff;
  logic                       div_busy;
  logic [ERR_BITS-1:0]        quot;
  logic [ERR_BITS-1:0]        emag;
  logic [ProdW-1:0]           prod_q;
  logic [ProdW:0]             rnd;
  logic [TmagW-1:0]           tmag;
  logic signed [WideW-1:0]    turn_mag;
  logic signed [WideW-1:0]    turn_w;
  logic signed [WideW-1:0]    cr_w;
  logic signed [VEL_BITS-1:0] cr_v;
  logic signed [VEL_BITS-1:0] sel_l, sel_r;
  logic [HOLD_BITS-1:0]       sel_hold;
  logic signed [VEL_BITS-1:0] held_l_q, held_r_q;
  logic                       out_valid_q;
  logic signed [VEL_BITS-1:0] out_l_q, out_r_q;
  logic [HOLD_BITS-1:0]       out_hold_q;
  logic [MODE_BITS-1:0]       out_mode_q;
  logic                       out_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sens) begin
      l_q <= left_sensor_i;
      c_q <= center_sensor_i;
      r_q <= right_sensor_i;
    end
  end

  assign sum   = SumW'(l_q) + SumW'(c_q) + SumW'(r_q);
  assign sum_c = CmpW'(sum);
  assign neg   = l_q < r_q;
  assign diff  = neg ? (r_q - l_q) : (l_q - r_q);

  assign status_o.sum_gt_join   = sum_c > CmpW'(cfg_i.join_threshold);
  assign status_o.sum_lt_lost   = sum_c < CmpW'(cfg_i.lost_threshold);
  assign status_o.sum_gt_bright = sum_c > CmpW'(cfg_i.bright_threshold);
  assign status_o.div_busy      = div_busy;
  assign status_o.out_busy      = out_valid_q && !res_o.ready;

  lfc_div #(
    .DivW (SumW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (SumW'(diff)),
    .divisor_i  (sum),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // A zero sum steers straight.
  assign emag = (sum == '0) ? '0 : quot;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      prod_q <= ProdW'(cfg_i.turn_gain) * ProdW'(emag);
    end
  end

  assign rnd      = {1'b0, prod_q} + RoundHalf;
  assign tmag     = rnd[ProdW:ERR_FRAC];
  assign turn_mag = WideW'(tmag);
  assign turn_w   = neg ? -turn_mag : turn_mag;
  assign cr_w     = WideW'(cfg_i.cruise_speed);
  assign cr_v     = VEL_BITS'(cfg_i.cruise_speed);

  always_comb begin
    unique case (cmd_i.kind)
      CMD_STOP: begin
        sel_l    = '0;
        sel_r    = '0;
        sel_hold = HOLD_START;
      end
      CMD_FWD: begin
        sel_l    = cr_v;
        sel_r    = cr_v;
        sel_hold = HOLD_PERIOD;
      end
      CMD_HELD: begin
        sel_l    = held_l_q;
        sel_r    = held_r_q;
        sel_hold = HOLD_PERIOD;
      end
      CMD_BODY: begin
        sel_l    = cr_v;
        sel_r    = cr_v;
        sel_hold = HOLD_BODY;
      end
      CMD_SPIN_Q: begin
        sel_l    = -cr_v;
        sel_r    = cr_v;
        sel_hold = HOLD_BITS'(cfg_i.quarter_turn_ms) + HOLD_PERIOD;
      end
      CMD_SPIN_H: begin
        sel_l    = -cr_v;
        sel_r    = cr_v;
        sel_hold = HOLD_BITS'(cfg_i.half_turn_ms) + HOLD_PERIOD;
      end
      CMD_STEER: begin
        sel_l    = sat_vel(cr_w + turn_w);
        sel_r    = sat_vel(cr_w - turn_w);
        sel_hold = HOLD_PERIOD;
      end
      default: begin
        sel_l    = '0;
        sel_r    = '0;
        sel_hold = HOLD_PERIOD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_l_q    <= '0;
      held_r_q    <= '0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
      held_l_q    <= sel_l;
      held_r_q    <= sel_r;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_l_q    <= sel_l;
      out_r_q    <= sel_r;
      out_hold_q <= sel_hold;
      out_mode_q <= cmd_i.mode_now;
      out_last_q <= cmd_i.last;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.left_velocity  = out_l_q;
  assign res_o.right_velocity = out_r_q;
  assign res_o.hold_ms        = out_hold_q;
  assign res_o.mode_now       = out_mode_q;
  assign res_o.last           = out_last_q;

endmodule

`default_nettype wire

### rtl/lfc_ctrl.sv
// ----------------------------------------------------------------------------
// lfc_ctrl: line follow sequencer
// State machine that holds the mode and straight count, decides each control
// period and steps the datapath through division, multiply and output.
// ----------------------------------------------------------------------------
`default_nettype none

module lfc_ctrl import lfc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [LIMIT_BITS-1:0] straight_limit_i,
  input  wire dp_status_t            status_i,
  output dp_cmd_t                    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_MUL,
    S_EMIT
  } state_e;

  state_e                state_q, state_d;
  logic [MODE_BITS-1:0]  mode_q, mode_d;
  logic [LIMIT_BITS-1:0] straight_q, straight_d;
  cmd_kind_e             kind_q, kind_d;
  logic                  last_q, last_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    straight_d    = straight_q;
    kind_d        = kind_q;
    last_d        = last_q;
    cmd_o         = '0;
    cmd_o.kind    = kind_q;
    cmd_o.last    = last_q;
    cmd_o.mode_now = mode_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_sens = 1'b1;
          state_d         = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_EMIT;
        last_d  = 1'b1;
        priority if (mode_q == MODE_SEEK) begin
          if (status_i.sum_gt_join) begin
            kind_d = CMD_FWD;
          end else begin
            kind_d = CMD_HELD;
            mode_d = MODE_FOLLOW;
          end
        end else if (mode_q == MODE_FOLLOW) begin
          priority if (status_i.sum_lt_lost) begin
            straight_d = '0;
            kind_d     = CMD_BODY;
            last_d     = 1'b0;
          end else if (status_i.sum_gt_bright) begin
            if (straight_q >= straight_limit_i) begin
              kind_d     = CMD_SPIN_H;
              straight_d = '0;
            end else begin
              kind_d     = CMD_FWD;
              straight_d = straight_q + 1'b1;
            end
          end else begin
            straight_d      = '0;
            kind_d          = CMD_STEER;
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
        end else begin
          // Start mode, and the unused mode code, stop the wheels.
          kind_d = CMD_STOP;
          mode_d = MODE_SEEK;
        end
      end
      S_DIV: begin
        if (!status_i.div_busy) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          if (last_q) begin
            state_d = S_IDLE;
          end else begin
            kind_d = CMD_SPIN_Q;
            last_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= MODE_START;
      straight_q <= '0;
      kind_q     <= CMD_STOP;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      straight_q <= straight_d;
      kind_q     <= kind_d;
      last_q     <= last_d;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !status_i.out_busy)
    else $error("Output register loaded while a transfer is pending.");

  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DECIDE))
    else $error("Accepted sensor transfer did not lead to a decision.");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && last_q) |=> in_ready_o)
    else $error("Sequencer did not return to idle after the final command.");

  a_div_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> status_i.div_busy)
    else $error("Divider did not start on request.");
`endif

endmodule

`default_nettype wire

### test/line_follow_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_follow_checker: wheel command predictor and comparator
// Watches the sensor channel, the command channel and register writes. It
// keeps its own copy of the mode, the bright-floor run, the held velocities
// and the registers. From each sensor transfer it works out the commands due.
// Each command transfer is compared with the oldest one still due.
// ----------------------------------------------------------------------------
module line_follow_checker import lfc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  lfc_sens_if                      sens_mon,
  lfc_cmd_if                       cmd_mon,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output int unsigned              fail_count,
  output int unsigned              cmds_due
);

  typedef struct packed {
    logic signed [VEL_BITS-1:0] left_velocity;
    logic signed [VEL_BITS-1:0] right_velocity;
    logic [HOLD_BITS-1:0]       hold_ms;
    logic [MODE_BITS-1:0]       mode_now;
    logic                       last;
  } wheel_cmd_t;

  localparam int VEL_HI       = 4095;
  localparam int VEL_LO       = -4096;
  localparam int ROUND_HALF   = 1 << (ERR_FRAC - 1);
  localparam int REPORT_LIMIT = 10;

  cfg_t                       cfg;
  logic [MODE_BITS-1:0]       ctl_mode;
  logic [LIMIT_BITS-1:0]      bright_run;
  logic signed [VEL_BITS-1:0] held_left;
  logic signed [VEL_BITS-1:0] held_right;
  wheel_cmd_t                 wheel_cmds_due[$];

  function automatic logic signed [VEL_BITS-1:0] clamp_vel(input int v);
    int c;
    c = (v > VEL_HI) ? VEL_HI : ((v < VEL_LO) ? VEL_LO : v);
    return c[VEL_BITS-1:0];
  endfunction

  task automatic issue_cmd(input int lv, input int rv, input int hold, input logic last);
    wheel_cmd_t cmd;
    cmd.left_velocity  = clamp_vel(lv);
    cmd.right_velocity = clamp_vel(rv);
    cmd.hold_ms        = hold[HOLD_BITS-1:0];
    cmd.mode_now       = ctl_mode;
    cmd.last           = last;
    held_left          = cmd.left_velocity;
    held_right         = cmd.right_velocity;
    wheel_cmds_due.push_back(cmd);
  endtask

  task automatic predict_wheel_cmds(input logic [SENSOR_BITS-1:0] ls,
                                    input logic [SENSOR_BITS-1:0] cs,
                                    input logic [SENSOR_BITS-1:0] rs);
    int sum;
    int cruise;
    int diff;
    int err_mag;
    int turn_mag;
    int turn;
    sum    = int'(ls) + int'(cs) + int'(rs);
    cruise = int'(cfg.cruise_speed);
    case (ctl_mode)
      MODE_SEEK: begin
        if (sum > int'(cfg.join_threshold)) begin
          issue_cmd(cruise, cruise, HOLD_PERIOD, 1'b1);
        end else begin
          ctl_mode = MODE_FOLLOW;
          issue_cmd(held_left, held_right, HOLD_PERIOD, 1'b1);
        end
      end
      MODE_FOLLOW: begin
        if (sum < int'(cfg.lost_threshold)) begin
          bright_run = '0;
          issue_cmd(cruise, cruise, HOLD_BODY, 1'b0);
          issue_cmd(-cruise, cruise, int'(cfg.quarter_turn_ms) + int'(HOLD_PERIOD), 1'b1);
        end else if (sum > int'(cfg.bright_threshold)) begin
          if (bright_run >= cfg.straight_limit) begin
            issue_cmd(-cruise, cruise, int'(cfg.half_turn_ms) + int'(HOLD_PERIOD), 1'b1);
            bright_run = '0;
          end else begin
            issue_cmd(cruise, cruise, HOLD_PERIOD, 1'b1);
            bright_run = bright_run + 1'b1;
          end
        end else begin
          // The error magnitude is truncated, the turn is rounded half away from zero.
          diff     = int'(ls) - int'(rs);
          err_mag  = (sum == 0) ? 0 : (((diff < 0) ? -diff : diff) << ERR_FRAC) / sum;
          turn_mag = (int'(cfg.turn_gain) * err_mag + ROUND_HALF) >>> ERR_FRAC;
          turn     = (diff < 0) ? -turn_mag : turn_mag;
          bright_run = '0;
          issue_cmd(cruise + turn, cruise - turn, HOLD_PERIOD, 1'b1);
        end
      end
      default: begin
        ctl_mode = MODE_SEEK;
        issue_cmd(0, 0, HOLD_START, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    wheel_cmd_t seen;
    wheel_cmd_t due;
    if (!rst_ni) begin
      cfg = '{cruise_speed: RST_CRUISE, turn_gain: RST_GAIN, lost_threshold: RST_LOST,
              bright_threshold: RST_BRIGHT, join_threshold: RST_JOIN,
              straight_limit: RST_LIMIT, quarter_turn_ms: RST_QUARTER,
              half_turn_ms: RST_HALF};
      ctl_mode   = MODE_START;
      bright_run = '0;
      held_left  = '0;
      held_right = '0;
      fail_count = 0;
      wheel_cmds_due.delete();
      cmds_due <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_BITS-1:2])
          REG_CRUISE:  cfg.cruise_speed     = pwdata[SPEED_BITS-1:0];
          REG_GAIN:    cfg.turn_gain        = pwdata[GAIN_BITS-1:0];
          REG_LOST:    cfg.lost_threshold   = pwdata[THR_BITS-1:0];
          REG_BRIGHT:  cfg.bright_threshold = pwdata[THR_BITS-1:0];
          REG_JOIN:    cfg.join_threshold   = pwdata[THR_BITS-1:0];
          REG_LIMIT:   cfg.straight_limit   = pwdata[LIMIT_BITS-1:0];
          REG_QUARTER: cfg.quarter_turn_ms  = pwdata[TURN_MS_BITS-1:0];
          REG_HALF:    cfg.half_turn_ms     = pwdata[TURN_MS_BITS-1:0];
          default: ;
        endcase
      end

      if (cmd_mon.valid && cmd_mon.ready) begin
        seen = '{left_velocity: cmd_mon.left_velocity,
                 right_velocity: cmd_mon.right_velocity,
                 hold_ms: cmd_mon.hold_ms, mode_now: cmd_mon.mode_now,
                 last: cmd_mon.last};
        if (wheel_cmds_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: command with none due: L %0d R %0d hold %0d mode %0d last %0d",
                     $realtime, seen.left_velocity, seen.right_velocity, seen.hold_ms,
                     seen.mode_now, seen.last);
        end else begin
          due = wheel_cmds_due.pop_front();
          if (seen.left_velocity !== due.left_velocity ||
              seen.right_velocity !== due.right_velocity ||
              seen.hold_ms !== due.hold_ms || seen.mode_now !== due.mode_now ||
              seen.last !== due.last) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("%0t: command mismatch: expected L %0d R %0d hold %0d mode %0d last %0d",
                       $realtime, due.left_velocity, due.right_velocity, due.hold_ms,
                       due.mode_now, due.last);
              $display("%0t:                   got      L %0d R %0d hold %0d mode %0d last %0d",
                       $realtime, seen.left_velocity, seen.right_velocity,
                       seen.hold_ms, seen.mode_now, seen.last);
            end
          end
        end
      end

      if (sens_mon.valid && sens_mon.ready)
        predict_wheel_cmds(sens_mon.left_sensor, sens_mon.center_sensor,
                           sens_mon.right_sensor);

      cmds_due <= wheel_cmds_due.size();
    end
  end

endmodule

### test/line_follow_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_follow_controller_tb: regression for the line follow controller
// A directed run walks through start, seek and every follow case. Random
// phases then go under several register settings, extremes among them, with
// the sender and the receiver idling at different rates. One long receiver
// hold-off backs the block up. A checker beside the block predicts and
// compares every wheel command.
// ----------------------------------------------------------------------------
module line_follow_controller_tb;
  import lfc_pkg::*;

  localparam int CLK_HALF_NS     = 4;
  localparam int RESET_CYCLES    = 8;
  localparam int PHASES          = 9;
  localparam int PHASE_ITEMS     = 125;
  localparam int DRAIN_CYCLES    = 40;
  localparam int IDLE_LIMIT      = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SENSOR_MAX      = (1 << SENSOR_BITS) - 1;
  localparam int SUM_MAX         = 3 * SENSOR_MAX;

  logic                     clk;
  logic                     rst_n;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic                     pready;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  int unsigned              fail_count;
  int unsigned              cmds_due;
  int unsigned              quiet_cycles;
  int unsigned              tx_idle_pct;
  int unsigned              rx_idle_pct;
  logic                     hold_off_req;
  logic                     hold_off_done;
  int unsigned              reg_val [8];

  lfc_sens_if sens_bus ();
  lfc_cmd_if  cmd_bus ();

  line_follow_controller dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .sens_i  (sens_bus),
    .res_o   (cmd_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  line_follow_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .sens_mon   (sens_bus),
    .cmd_mon    (cmd_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .cmds_due   (cmds_due)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  // Command receiver; it serves one long hold-off on request.
  initial begin
    cmd_bus.ready = 1'b0;
    hold_off_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        cmd_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        cmd_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (sens_bus.valid && sens_bus.ready) || (cmd_bus.valid && cmd_bus.ready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_reading(input int l, input int c, input int r);
    logic taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      sens_bus.valid <= 1'b0;
      @(posedge clk);
    end
    sens_bus.valid         <= 1'b1;
    sens_bus.left_sensor   <= l[SENSOR_BITS-1:0];
    sens_bus.center_sensor <= c[SENSOR_BITS-1:0];
    sens_bus.right_sensor  <= r[SENSOR_BITS-1:0];
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = sens_bus.ready;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input int unsigned idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'(idx << 2);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_block();
    sens_bus.valid <= 1'b0;
    @(posedge clk);
    while (cmds_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_phase_regs(input int phase);
    case (phase)
      1: begin
        reg_val[REG_CRUISE]  = 2047;
        reg_val[REG_GAIN]    = 4095;
        reg_val[REG_LOST]    = 16383;
        reg_val[REG_BRIGHT]  = 16383;
        reg_val[REG_JOIN]    = 16383;
        reg_val[REG_LIMIT]   = 15;
        reg_val[REG_QUARTER] = 8191;
        reg_val[REG_HALF]    = 8191;
      end
      3: begin
        foreach (reg_val[i]) reg_val[i] = 0;
      end
      default: begin
        reg_val[REG_CRUISE]  = $urandom_range(2047);
        reg_val[REG_GAIN]    = $urandom_range(4095);
        reg_val[REG_LOST]    = $urandom_range(4000);
        reg_val[REG_BRIGHT]  = $urandom_range(13000, 800);
        reg_val[REG_JOIN]    = $urandom_range(16383);
        reg_val[REG_LIMIT]   = $urandom_range(15);
        reg_val[REG_QUARTER] = $urandom_range(8191);
        reg_val[REG_HALF]    = $urandom_range(8191);
        if (phase == 4) begin
          // Lost threshold above the bright one: the lost test must win.
          reg_val[REG_LOST]   = 3000;
          reg_val[REG_BRIGHT] = 1500;
        end
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(i, reg_val[i]);
  endtask

  task automatic pick_reading(output int l, output int c, output int r);
    int pick;
    int cap;
    int lo;
    int hi;
    int total;
    int swap;
    pick = $urandom_range(99);
    if (pick < 35) begin
      l = $urandom_range(SENSOR_MAX);
      c = $urandom_range(SENSOR_MAX);
      r = $urandom_range(SENSOR_MAX);
    end else if (pick < 50) begin
      l = $urandom_range(1) ? SENSOR_MAX : 0;
      c = $urandom_range(1) ? SENSOR_MAX : 0;
      r = $urandom_range(1) ? SENSOR_MAX : 0;
    end else if (pick < 70) begin
      cap = reg_val[REG_LOST] / 3;
      if (cap > SENSOR_MAX) cap = SENSOR_MAX;
      l = $urandom_range(cap);
      c = $urandom_range(cap);
      r = $urandom_range(cap);
    end else begin
      // Aim the sum at the steering band between the two thresholds.
      lo = reg_val[REG_LOST];
      hi = reg_val[REG_BRIGHT];
      if (hi > SUM_MAX) hi = SUM_MAX;
      if (lo > hi) begin
        lo = 0;
        hi = SUM_MAX;
      end
      total = $urandom_range(hi, lo);
      l = $urandom_range((total < SENSOR_MAX) ? total : SENSOR_MAX,
                         (total > 2 * SENSOR_MAX) ? total - 2 * SENSOR_MAX : 0);
      total = total - l;
      c = $urandom_range((total < SENSOR_MAX) ? total : SENSOR_MAX,
                         (total > SENSOR_MAX) ? total - SENSOR_MAX : 0);
      r = total - c;
      if ($urandom_range(1)) begin
        swap = l;
        l    = r;
        r    = swap;
      end
    end
  endtask

  initial begin
    int l;
    int c;
    int r;
    rst_n                  = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    sens_bus.valid         = 1'b0;
    sens_bus.left_sensor   = '0;
    sens_bus.center_sensor = '0;
    sens_bus.right_sensor  = '0;
    hold_off_req           = 1'b0;
    tx_idle_pct            = 35;
    rx_idle_pct            = 88;
    reg_val[REG_CRUISE]    = RST_CRUISE;
    reg_val[REG_GAIN]      = RST_GAIN;
    reg_val[REG_LOST]      = RST_LOST;
    reg_val[REG_BRIGHT]    = RST_BRIGHT;
    reg_val[REG_JOIN]      = RST_JOIN;
    reg_val[REG_LIMIT]     = RST_LIMIT;
    reg_val[REG_QUARTER]   = RST_QUARTER;
    reg_val[REG_HALF]      = RST_HALF;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Start, two seek periods, then a sum equal to the join threshold.
    send_reading(0, 0, 0);
    send_reading(SENSOR_MAX, SENSOR_MAX, SENSOR_MAX);
    send_reading(801, 800, 800);
    send_reading(800, 800, 800);
    // Lost line, at zero and just under the threshold.
    send_reading(0, 0, 0);
    send_reading(333, 333, 333);
    // Steering: full error both ways, threshold edges, zero error.
    send_reading(1000, 0, 0);
    send_reading(0, 0, 2500);
    send_reading(834, 833, 833);
    send_reading(700, 600, 700);
    send_reading(1200, 100, 0);
    // A bright run long enough to end in a half turn.
    send_reading(2501, 0, 0);
    for (int i = 0; i < 10; i++) send_reading(SENSOR_MAX, SENSOR_MAX, SENSOR_MAX);
    send_reading(0, SENSOR_MAX, 0);
    send_reading(0, 1500, 0);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        drain_block();
        set_phase_regs(phase);
      end
      case (phase / 3)
        0: begin
          tx_idle_pct = 35;
          rx_idle_pct = 88;
        end
        1: begin
          tx_idle_pct = 88;
          rx_idle_pct = 35;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (phase == 6) hold_off_req <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick_reading(l, c, r);
        send_reading(l, c, r);
      end
    end

    drain_block();
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
